[src/lz_arrival_cost_relaxation_core_assert.svh]
// Assertion macros for the arrival-cost relaxation core.
// Used by the controller and the top level; no other dependencies.
`ifndef LZ_ARRIVAL_COST_RELAXATION_CORE_ASSERT_SVH
`define LZ_ARRIVAL_COST_RELAXATION_CORE_ASSERT_SVH
// implication checked at every edge outside reset
`define LZA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define LZA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/lzac_pkg.sv]
// Package for the arrival-cost relaxation core: constants, codes and types.
// No dependencies.
package lzac_pkg;
    localparam int COST_W = 24;
    localparam int POS_W = 13;
    localparam int RUN_W = 13;
    localparam logic [23:0] COST_MAX = 24'hFFFFFF;
    localparam logic [12:0] RUN_MAX = 13'h1FFF;
    localparam logic [3:0] REPEAT_ONE_COST = 4'd4;
    localparam logic [3:0] LITERAL_BITS = 4'd7;

    // block geometry and match limits
    localparam int BLOCK_LEN = 4096;
    localparam int OFFSET_LIMIT = 65536;
    localparam int MATCH_LEN_LIMIT = 255;

    localparam logic [1:0] MODE_OPEN = 2'd0;
    localparam logic [1:0] MODE_LIT = 2'd1;
    localparam logic [1:0] MODE_MATCH = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [1:0] CFG_LIT_RUN = 2'd0;
    localparam logic [1:0] CFG_LEN = 2'd1;
    localparam logic [1:0] CFG_OFF = 2'd2;
    localparam logic [1:0] CFG_GOOD = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch request fields
        logic rd_src;    // read source entry (and write history byte)
        logic rd_tgt;    // read target entry
        logic calc;      // register candidate cost
        logic commit;    // write target, emit result
        logic clr_wr;    // write one clearing entry
        logic clr_adv;   // advance clear pointer
        logic emit_nop;  // emit all-zero result
    } lzac_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_ok;    // request valid for its mode
        logic clr_last;  // clear pointer past last entry
        logic clearing;  // post-reset clearing pass running
    } lzac_sts_t;

    // floor(log2(v)), 0 for 0
    function automatic logic [4:0] bit_count(input logic [15:0] v);
        logic [4:0] b;
        b = 5'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (v[i])
                b = 5'(i);
        end
        return b;
    endfunction
endpackage

[src/lz_arrival_cost_relaxation_core.sv]
// Channel  | handshake            | fields
// input    | start / busy         | mode position end_position data_byte match_offset match_length
// config   | cfg_we               | cfg_index cfg_data (8 bits)
// result   | done (one cycle)     | step_cost improved skip_ahead entry_cost entry_length
//          |                      | entry_offset entry_literals
// Literal, match and read: check, source read, target read, compute and commit run in
// order and done is registered from commit; one memory read port serves both entries.
// Open span: entries from position through end_position (capped at BLOCK_LEN) are
// written, one entry per cycle. A rejected transaction gives done in the cycle after its check.
// After reset a clearing pass over all BLOCK_LEN + 1 entries runs; a transaction taken
// in it holds in check until the pass ends. The receiver cannot stall; done lasts one cycle.
`include "lz_arrival_cost_relaxation_core_assert.svh"
module lz_arrival_cost_relaxation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [12:0] position,
    input  logic [12:0] end_position,
    input  logic [7:0]  data_byte,
    input  logic [15:0] match_offset,
    input  logic [7:0]  match_length,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [23:0] step_cost,
    output logic        improved,
    output logic [7:0]  skip_ahead,
    output logic [23:0] entry_cost,
    output logic [7:0]  entry_length,
    output logic [15:0] entry_offset,
    output logic [12:0] entry_literals
);
    logic [4:0] lit_cost_reg, len_cost_reg, off_cost_reg;
    logic [7:0] good_reg;
    lzac_pkg::lzac_cmd_t cmd;
    lzac_pkg::lzac_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_cost_reg <= 5'd2;
            len_cost_reg <= 5'd2;
            off_cost_reg <= 5'd3;
            good_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lzac_pkg::CFG_LIT_RUN: lit_cost_reg <= cfg_data[4:0];
                lzac_pkg::CFG_LEN: len_cost_reg <= cfg_data[4:0];
                lzac_pkg::CFG_OFF: off_cost_reg <= cfg_data[4:0];
                lzac_pkg::CFG_GOOD: good_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lzac_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    lzac_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .mode(mode), .position(position), .end_position(end_position),
        .data_byte(data_byte), .match_offset(match_offset),
        .match_length(match_length),
        .lit_cost(lit_cost_reg), .len_cost(len_cost_reg),
        .off_cost(off_cost_reg), .good_len(good_reg),
        .done(done), .step_cost(step_cost), .improved(improved),
        .skip_ahead(skip_ahead), .entry_cost(entry_cost),
        .entry_length(entry_length), .entry_offset(entry_offset),
        .entry_literals(entry_literals)
    );

    `LZA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `LZA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `LZA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
endmodule

[src/lzac_ctrl.sv]
// Controller of the arrival-cost relaxation core.
// Depends on lzac_pkg and the assertion macro header.
`include "lz_arrival_cost_relaxation_core_assert.svh"
module lzac_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  lzac_pkg::lzac_sts_t sts,
    output logic                busy,
    output lzac_pkg::lzac_cmd_t cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SRC = 3'd2;
    localparam logic [2:0] ST_TGT = 3'd3;
    localparam logic [2:0] ST_CALC = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;
    localparam logic [2:0] ST_CLEAR = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg <= lzac_pkg::MODE_OPEN;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    mode_next = mode;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.clearing)
                begin
                    // hold until the post-reset clear is done
                    state_next = ST_CHECK;
                end
                else if (!sts.req_ok)
                begin
                    cmd.emit_nop = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (mode_reg == lzac_pkg::MODE_OPEN)
                begin
                    cmd.clr_wr = 1'b1;
                    cmd.clr_adv = 1'b1;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    cmd.rd_src = 1'b1;
                    state_next = ST_SRC;
                end
            end
            ST_SRC:
            begin
                cmd.rd_tgt = 1'b1;
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                cmd.calc = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    cmd.emit_nop = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.clr_wr = 1'b1;
                    cmd.clr_adv = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `LZA_ASSERT_IMP(a_one_result, clk, rst_n, cmd.commit, !cmd.emit_nop)
    `LZA_ASSERT_NEXT(a_commit_idle, clk, rst_n, cmd.commit, !busy)
    `LZA_ASSERT_NEXT(a_capture_busy, clk, rst_n, cmd.capture, busy)
endmodule

[src/lzac_datapath.sv]
// Datapath of the arrival-cost relaxation core: entry memories, history,
// span clear pointer and cost arithmetic. Depends on lzac_pkg.
module lzac_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lzac_pkg::lzac_cmd_t cmd,
    output lzac_pkg::lzac_sts_t sts,
    input  logic [1:0]          mode,
    input  logic [12:0]         position,
    input  logic [12:0]         end_position,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         match_offset,
    input  logic [7:0]          match_length,
    input  logic [4:0]          lit_cost,
    input  logic [4:0]          len_cost,
    input  logic [4:0]          off_cost,
    input  logic [7:0]          good_len,
    output logic                done,
    output logic [23:0]         step_cost,
    output logic                improved,
    output logic [7:0]          skip_ahead,
    output logic [23:0]         entry_cost,
    output logic [7:0]          entry_length,
    output logic [15:0]         entry_offset,
    output logic [12:0]         entry_literals
);
    localparam int BLOCK_LEN = lzac_pkg::BLOCK_LEN;
    localparam int OFFSET_LIMIT = lzac_pkg::OFFSET_LIMIT;
    localparam int MATCH_LEN_LIMIT = lzac_pkg::MATCH_LEN_LIMIT;
    localparam int DEPTH = BLOCK_LEN + 1;
    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(BLOCK_LEN);
    localparam int PW = AW + 1;

    // entry memories; cost stored inverted so zero-clear means unreached
    logic [23:0] cost_mem [DEPTH];
    logic [7:0]  len_mem [DEPTH];
    logic [15:0] off_mem [DEPTH];
    logic [15:0] rep_mem [DEPTH];
    logic [12:0] run_mem [DEPTH];
    logic [7:0]  hist_mem [BLOCK_LEN];
    // clearing pass after reset
    logic [AW:0] init_reg;
    logic        init_busy;

    logic [1:0]  mode_reg;
    logic [PW-1:0] pos_reg, end_reg, clr_reg, clr_next;
    logic [7:0]  byte_reg, len_reg;
    logic [15:0] moff_reg;

    logic [AW-1:0] rd_addr, wr_addr;
    logic [23:0] rd_cost;
    logic [7:0]  rd_len;
    logic [15:0] rd_off, rd_rep;
    logic [12:0] rd_run;
    logic [7:0]  rd_hist;
    logic [7:0]  rd_len_hold;
    logic [15:0] rd_off_hold;

    logic [23:0] s_cost_reg, t_cost_reg, cand_reg;
    logic [15:0] s_rep_reg, offs_reg, nrep_reg;
    logic [12:0] s_run_reg, nrun_reg;
    logic        s_hist_ok_reg;

    logic [PW-1:0] tgt;
    logic [PW-1:0] end_cl;
    logic [PW:0]   pos_len;
    logic          we;
    logic [23:0]   w_cost;
    logic [7:0]    w_len;
    logic [15:0]   w_off, w_rep;
    logic [12:0]   w_run;
    logic          w_full;

    assign init_busy = (init_reg <= (AW+1)'(BLOCK_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg <= '0;
        else if (init_busy)
            init_reg <= init_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            pos_reg <= PW'(position);
            end_reg <= PW'(end_position);
            byte_reg <= data_byte;
            moff_reg <= match_offset;
            len_reg <= match_length;
        end
    end

    assign pos_len = (PW+1)'(pos_reg) + (PW+1)'(len_reg);
    assign end_cl = (end_reg > PW'(BLOCK_LEN)) ? PW'(BLOCK_LEN) : end_reg;

    always_comb
    begin
        sts.req_ok = 1'b0;
        sts.clearing = init_busy;
        sts.clr_last = (clr_reg > end_cl) || (clr_reg > PW'(BLOCK_LEN));
        case (mode_reg)
            lzac_pkg::MODE_OPEN: sts.req_ok = (pos_reg <= PW'(BLOCK_LEN)) && !init_busy;
            lzac_pkg::MODE_LIT: sts.req_ok = (pos_reg < PW'(BLOCK_LEN)) && !init_busy;
            lzac_pkg::MODE_MATCH:
                sts.req_ok = (len_reg != 8'd0) && (32'(len_reg) <= MATCH_LEN_LIMIT)
                    && (32'(moff_reg) < OFFSET_LIMIT)
                    && (pos_len <= (PW+1)'(BLOCK_LEN)) && !init_busy;
            default: sts.req_ok = (pos_reg <= PW'(BLOCK_LEN)) && !init_busy;
        endcase
    end

    always_comb
    begin
        clr_next = clr_reg;
        if (cmd.clr_adv)
            clr_next = clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            clr_reg <= PW'(position);
        else
            clr_reg <= clr_next;
    end

    assign tgt = (mode_reg == lzac_pkg::MODE_LIT) ? pos_reg + 1'b1 : pos_len[PW-1:0];
    assign rd_addr = cmd.rd_tgt ? tgt[AW-1:0] : pos_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        rd_cost <= ~cost_mem[rd_addr];
        rd_len <= len_mem[rd_addr];
        rd_off <= off_mem[rd_addr];
        rd_rep <= rep_mem[rd_addr];
        rd_run <= run_mem[rd_addr];
    end

    // write port: init clear, span clear, or commit
    always_comb
    begin
        we = 1'b0;
        wr_addr = clr_reg[AW-1:0];
        w_cost = lzac_pkg::COST_MAX;
        w_len = len_reg;
        w_off = offs_reg;
        w_rep = nrep_reg;
        w_run = '0;
        w_full = 1'b0;
        if (init_busy)
        begin
            we = 1'b1;
            wr_addr = init_reg[AW-1:0];
        end
        else if (cmd.clr_wr)
        begin
            we = 1'b1;
            if (clr_reg == pos_reg)
            begin
                w_cost = '0;
                w_rep = moff_reg;
            end
        end
        else if (cmd.commit && (mode_reg == lzac_pkg::MODE_LIT
                 ? (t_cost_reg >= cand_reg) : (t_cost_reg > cand_reg))
                 && (mode_reg == lzac_pkg::MODE_LIT || mode_reg == lzac_pkg::MODE_MATCH))
        begin
            we = 1'b1;
            wr_addr = tgt[AW-1:0];
            w_cost = cand_reg;
            w_run = nrun_reg;
            w_full = 1'b1;
            if (mode_reg == lzac_pkg::MODE_LIT)
                w_len = 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cost_mem[wr_addr] <= ~w_cost;
            run_mem[wr_addr] <= w_run;
            if (w_full || (cmd.clr_wr && clr_reg == pos_reg))
                rep_mem[wr_addr] <= w_rep;
            if (w_full)
            begin
                len_mem[wr_addr] <= w_len;
                off_mem[wr_addr] <= w_off;
            end
        end
    end

    // history: write byte on the source read of a literal, read back at pos - rep
    logic [PW-1:0] hist_ra;
    assign hist_ra = pos_reg - PW'(rd_rep);
    always_ff @(posedge clk)
    begin
        if (cmd.rd_src && mode_reg == lzac_pkg::MODE_LIT)
            hist_mem[pos_reg[HW-1:0]] <= byte_reg;
        if (cmd.rd_tgt)
            rd_hist <= hist_mem[hist_ra[HW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_tgt)
        begin
            s_cost_reg <= rd_cost;
            s_rep_reg <= rd_rep;
            s_run_reg <= rd_run;
            s_hist_ok_reg <= (32'(pos_reg) >= 32'(rd_rep));
        end
        if (cmd.calc)
            t_cost_reg <= rd_cost;
    end

    // candidate cost; hist read uses rep==0 case: byte just written
    logic [25:0] cost_c;
    logic        rep_hit;
    logic [12:0] run_n;
    logic [15:0] offs_c;
    logic [15:0] rep_c;
    always_comb
    begin
        cost_c = 26'(s_cost_reg) + 26'd1;
        run_n = s_run_reg;
        offs_c = '0;
        rep_c = s_rep_reg;
        rep_hit = 1'b0;
        if (mode_reg == lzac_pkg::MODE_LIT)
        begin
            rep_hit = s_hist_ok_reg &&
                ((s_rep_reg == 16'd0) || (rd_hist == byte_reg));
            if (rep_hit)
            begin
                offs_c = s_rep_reg;
                run_n = 13'd1;
                cost_c = cost_c + 26'(lzac_pkg::REPEAT_ONE_COST);
            end
            else
            begin
                cost_c = cost_c + 26'(lzac_pkg::LITERAL_BITS);
                if (s_run_reg != 13'd0)
                    cost_c = cost_c - 26'(lzac_pkg::bit_count(16'(s_run_reg)));
                if (s_run_reg != lzac_pkg::RUN_MAX)
                    run_n = s_run_reg + 1'b1;
            end
            cost_c = cost_c + 26'(lzac_pkg::bit_count(16'(run_n))) + 26'(lit_cost);
        end
        else
        begin
            offs_c = moff_reg;
            if (s_hist_ok_reg && moff_reg == s_rep_reg)
                offs_c = '0;
            else
                rep_c = moff_reg;
            if (offs_c != 16'd0)
                cost_c = cost_c + 26'(lzac_pkg::bit_count(offs_c)) + 26'(off_cost);
            cost_c = cost_c + 26'(lzac_pkg::bit_count(16'(len_reg))) + 26'(len_cost);
            run_n = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            cand_reg <= (cost_c > 26'(lzac_pkg::COST_MAX)) ? lzac_pkg::COST_MAX : cost_c[23:0];
            offs_reg <= offs_c;
            nrep_reg <= rep_c;
            nrun_reg <= (offs_c == 16'd0) ? run_n : 13'd0;
        end
    end

    // result register
    logic        done_reg;
    logic [23:0] step_cost_reg, entry_cost_reg;
    logic        improved_reg;
    logic [7:0]  skip_reg, entry_length_reg;
    logic [15:0] entry_offset_reg;
    logic [12:0] entry_literals_reg;
    logic        better;
    assign better = (mode_reg == lzac_pkg::MODE_LIT) ? (t_cost_reg >= cand_reg)
                                                    : (t_cost_reg > cand_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.commit || cmd.emit_nop;
    end

    always_ff @(posedge clk)
    begin
        step_cost_reg <= '0;
        improved_reg <= 1'b0;
        skip_reg <= '0;
        entry_cost_reg <= '0;
        entry_length_reg <= '0;
        entry_offset_reg <= '0;
        entry_literals_reg <= '0;
        if (cmd.commit)
        begin
            if (mode_reg == lzac_pkg::MODE_READ)
            begin
                entry_cost_reg <= s_cost_reg;
                entry_length_reg <= rd_len_hold;
                entry_offset_reg <= rd_off_hold;
                entry_literals_reg <= s_run_reg;
            end
            else
            begin
                step_cost_reg <= cand_reg;
                improved_reg <= better;
                if (mode_reg == lzac_pkg::MODE_MATCH)
                    skip_reg <= (len_reg >= good_len) ? good_len : 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_tgt)
        begin
            rd_len_hold <= rd_len;
            rd_off_hold <= rd_off;
        end
    end

    assign done = done_reg;
    assign step_cost = step_cost_reg;
    assign improved = improved_reg;
    assign skip_ahead = skip_reg;
    assign entry_cost = entry_cost_reg;
    assign entry_length = entry_length_reg;
    assign entry_offset = entry_offset_reg;
    assign entry_literals = entry_literals_reg;
endmodule
